>>> hdl/lis_pkg.sv
`default_nettype none

package lis_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_BT_START,
    ST_BT_IDX,
    ST_BT_RD,
    ST_BT_WR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } lis_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic drop;
    logic scan;
    logic update;
    logic bt_start;
    logic bt_idx;
    logic bt_rd;
    logic bt_wr;
    logic emit_rd;
    logic emit_ld;
  } lis_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_take;
    logic scan_done;
    logic bt_last;
    logic emit_last;
    logic out_free;
  } lis_sts_t;

endpackage

`default_nettype wire

>>> hdl/lis_ctrl.sv
`default_nettype none

module lis_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              is_final_i,
  output logic                   in_stall_o,
  input  wire lis_pkg::lis_sts_t sts_i,
  output lis_pkg::lis_cmd_t      cmd_o
);
  import lis_pkg::*;

  lis_state_e state_q, state_d;
  logic       fin_q, fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          fin_d = is_final_i;
          if (sts_i.can_take) begin
            state_d = ST_SCAN;
          end else if (is_final_i) begin
            state_d = ST_BT_START;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = fin_q ? ST_BT_START : ST_IDLE;
      end
      ST_BT_START: state_d = ST_BT_IDX;
      ST_BT_IDX:   state_d = ST_BT_RD;
      ST_BT_RD:    state_d = ST_BT_WR;
      ST_BT_WR: begin
        state_d = sts_i.bt_last ? ST_EMIT_RD : ST_BT_RD;
      end
      ST_EMIT_RD:  state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.take   = in_valid_i & sts_i.can_take;
        cmd_o.drop   = in_valid_i & ~sts_i.can_take;
      end
      ST_SCAN:     cmd_o.scan     = 1'b1;
      ST_UPDATE:   cmd_o.update   = 1'b1;
      ST_BT_START: cmd_o.bt_start = 1'b1;
      ST_BT_IDX:   cmd_o.bt_idx   = 1'b1;
      ST_BT_RD:    cmd_o.bt_rd    = 1'b1;
      ST_BT_WR:    cmd_o.bt_wr    = 1'b1;
      ST_EMIT_RD:  cmd_o.emit_rd  = 1'b1;
      ST_EMIT_LD:  cmd_o.emit_ld  = sts_i.out_free;
      default:     cmd_o          = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/lis_dp.sv
`default_nettype none

module lis_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire lis_pkg::lis_cmd_t                  cmd_i,
  output lis_pkg::lis_sts_t                       sts_o,
  input  wire logic signed [lis_pkg::VALUE_W-1:0] in_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [lis_pkg::VALUE_W-1:0]      out_value_o,
  output logic [lis_pkg::LEN_W-1:0]               seq_length_o,
  output logic                                    end_of_run_o,
  output logic                                    overflowed_o
);
  import lis_pkg::*;

  localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  // memories
  logic [VALUE_W-1:0] value_mem [MAX_ITEMS];
  logic [IW-1:0]      tail_mem  [MAX_ITEMS];  // entry n holds the tail of length n+1
  logic [IW-1:0]      pred_mem  [MAX_ITEMS];
  logic [VALUE_W-1:0] path_mem  [MAX_ITEMS];

  logic [VALUE_W-1:0] value_rdata_q;
  logic [IW-1:0]      tail_rdata_q;
  logic [IW-1:0]      pred_rdata_q;
  logic [VALUE_W-1:0] path_rdata_q;

  // control state
  logic [CW-1:0] count_q, best_len_q, j_q, j1_q, j2_q, best_j_q, k_q, e_q;
  logic          ovf_q, s1_v_q, s2_v_q, next_lt_q, out_valid_q;
  // payload
  logic signed [VALUE_W-1:0] key_q;
  logic [IW-1:0]             idx_q, t2_q, tbest_q, cur_idx_q;
  logic [VALUE_W-1:0]        out_value_q;
  logic [LEN_W-1:0]          seq_len_q;
  logic                      end_q, ovf_out_q;

  logic          scan_issue, extend, lt, emit_last, out_free;
  logic [IW-1:0] tail_raddr, value_raddr;

  assign scan_issue  = cmd_i.scan && (j_q <= best_len_q);
  assign extend      = (best_j_q == best_len_q) || next_lt_q;
  assign lt          = $signed(value_rdata_q) < key_q;
  assign emit_last   = (e_q == best_len_q - CW'(1));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign tail_raddr  = cmd_i.bt_start ? IW'(best_len_q - CW'(1)) : IW'(j_q - CW'(1));
  assign value_raddr = cmd_i.bt_rd ? cur_idx_q : tail_rdata_q;

  assign sts_o.can_take  = (count_q < CW'(MAX_ITEMS));
  assign sts_o.scan_done = (j_q > best_len_q) && !s1_v_q && !s2_v_q;
  assign sts_o.bt_last   = (k_q == CW'(1));
  assign sts_o.emit_last = emit_last;
  assign sts_o.out_free  = out_free;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      value_mem[count_q[IW-1:0]] <= in_value_i;
    end
    if (s1_v_q || cmd_i.bt_rd) begin
      value_rdata_q <= value_mem[value_raddr];
    end
    if (cmd_i.update && extend) begin
      tail_mem[best_j_q[IW-1:0]] <= idx_q;
    end
    if (scan_issue || cmd_i.bt_start) begin
      tail_rdata_q <= tail_mem[tail_raddr];
    end
    if (cmd_i.update) begin
      pred_mem[idx_q] <= tbest_q;
    end
    if (cmd_i.bt_rd) begin
      pred_rdata_q <= pred_mem[cur_idx_q];
    end
    if (cmd_i.bt_wr) begin
      path_mem[IW'(k_q - CW'(1))] <= value_rdata_q;
    end
    if (cmd_i.emit_rd) begin
      path_rdata_q <= path_mem[e_q[IW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      key_q   <= in_value_i;
      idx_q   <= count_q[IW-1:0];
      tbest_q <= '0;
    end
    if (s1_v_q) begin
      t2_q <= tail_rdata_q;
    end
    if (s2_v_q && lt) begin
      tbest_q <= t2_q;
    end
    if (cmd_i.bt_idx) begin
      cur_idx_q <= tail_rdata_q;
    end else if (cmd_i.bt_wr) begin
      cur_idx_q <= pred_rdata_q;
    end
    if (cmd_i.emit_ld) begin
      out_value_q <= path_rdata_q;
      seq_len_q   <= LEN_W'(best_len_q);
      end_q       <= emit_last;
      ovf_out_q   <= ovf_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      best_len_q  <= '0;
      ovf_q       <= 1'b0;
      j_q         <= '0;
      j1_q        <= '0;
      j2_q        <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      best_j_q    <= '0;
      next_lt_q   <= 1'b0;
      k_q         <= '0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // scan pipeline: tail read, value read, compare
      s1_v_q <= scan_issue;
      s2_v_q <= s1_v_q;
      j1_q   <= j_q;
      j2_q   <= j1_q;
      if (cmd_i.take) begin
        j_q       <= CW'(1);
        best_j_q  <= '0;
        next_lt_q <= 1'b0;
      end else if (scan_issue) begin
        j_q <= j_q + CW'(1);
      end
      if (s2_v_q) begin
        if (lt) begin
          best_j_q  <= j2_q;
          next_lt_q <= 1'b0;
        end else if (j2_q == best_j_q + CW'(1)) begin
          next_lt_q <= key_q < $signed(value_rdata_q);
        end
      end

      if (cmd_i.drop) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.update) begin
        count_q <= count_q + CW'(1);
        if (best_j_q == best_len_q) begin
          best_len_q <= best_len_q + CW'(1);
        end
      end

      if (cmd_i.bt_start) begin
        k_q <= best_len_q;
        e_q <= '0;
      end else if (cmd_i.bt_wr) begin
        k_q <= k_q - CW'(1);
      end

      if (cmd_i.emit_ld) begin
        e_q <= e_q + CW'(1);
        if (emit_last) begin
          count_q    <= '0;
          best_len_q <= '0;
          ovf_q      <= 1'b0;
        end
      end

      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = $signed(out_value_q);
  assign seq_length_o = seq_len_q;
  assign end_of_run_o = end_q;
  assign overflowed_o = ovf_out_q;

endmodule

`default_nettype wire

>>> hdl/longest_increasing_subsequence.sv
// longest strictly increasing subsequence of a streamed sequence
//
// input channel: in_value_i / is_final_i, transfer when in_valid_i is high and
// in_stall_o is low. is_final_i marks the last element of a sequence. up to
// MAX_ITEMS elements are kept; later ones are dropped and flag overflowed_o
// on the results (a dropped final element still ends the sequence).
// output channel: one transfer per subsequence element, smallest first, with
// seq_length_o on every element and end_of_run_o on the last one.
// per element: a linear scan of the tail memory through a two-stage read
// pipeline, over every chain length found so far, then the update step.
// after the final element: a start and an index step set up the walk of the
// predecessor chain, then a read and a write step per element walk it, and
// a read and a load step per result emit it while the receiver does not stall.
// the block takes one element at a time; in_stall_o is low only when idle,
// and the output register lets the block take new elements while the last
// result still waits. a stalled result holds its value.
// reset clears all control state; the memories need no clearing since no
// entry is read before it is written in the same sequence.
`default_nettype none

module longest_increasing_subsequence #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [lis_pkg::VALUE_W-1:0] in_value_i,
  input  wire logic                               is_final_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [lis_pkg::VALUE_W-1:0]      out_value_o,
  output logic [lis_pkg::LEN_W-1:0]               seq_length_o,
  output logic                                    end_of_run_o,
  output logic                                    overflowed_o
);
  import lis_pkg::*;

  lis_cmd_t cmd;
  lis_sts_t sts;

  // sequencer: accept, scan, update, backtrack, emit
  lis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_final_i (is_final_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, scan pipeline, counters and output register
  lis_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_value_i   (in_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .seq_length_o (seq_length_o),
    .end_of_run_o (end_of_run_o),
    .overflowed_o (overflowed_o)
  );

  // a result always carries a nonzero length within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (seq_length_o != '0) && (seq_length_o <= LEN_W'(MAX_ITEMS)))
    else $error("result length out of range");

  // a stored element always starts a scan, so the input stalls next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts.can_take) |=> in_stall_o)
    else $error("input not stalled during scan");

  // the sequencer issues at most one command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lis_pkg::*;

  // capacity of the block, kept equal to its default
  localparam int unsigned MAX_ITEMS   = 64;
  // elements to send over the whole run, directed rows included
  localparam int unsigned ITEM_TARGET = 480;
  // the final stretch of the run runs with both sides idle-free
  localparam int unsigned QUIET_TAIL  = 70;
  // generous cycle budget
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // cycles to linger after the last expected transfer
  localparam int unsigned DRAIN_WAIT  = 100;

  // flavor of the values in one random sequence
  typedef enum int {
    MIX_RANDOM,
    MIX_NARROW,
    MIX_RISING,
    MIX_FALLING,
    MIX_EXTREME
  } value_mix_e;

  // one expected subsequence element, as it appears on the output channel
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [LEN_W-1:0]          len;
    logic                      last;
    logic                      ovf;
  } subseq_elem_t;

  // one directed row; single-element sequences carry their result typed in
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
    bit                        typed;
    logic signed [VALUE_W-1:0] exp_value;
    logic [LEN_W-1:0]          exp_len;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 23;

  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // lone elements: the subsequence is the element itself
    '{32'sd0,  1'b1, 1'b1, 32'sd0,  7'd1},
    '{VMIN,    1'b1, 1'b1, VMIN,    7'd1},
    '{VMAX,    1'b1, 1'b1, VMAX,    7'd1},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1, 7'd1},
    // full-range rise, then full-range fall
    '{VMIN,    1'b0, 1'b0, 32'sd0,  7'd0},
    '{VMAX,    1'b1, 1'b0, 32'sd0,  7'd0},
    '{VMAX,    1'b0, 1'b0, 32'sd0,  7'd0},
    '{VMIN,    1'b1, 1'b0, 32'sd0,  7'd0},
    // equal values never chain
    '{32'sd5,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd5,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd5,  1'b1, 1'b0, 32'sd0,  7'd0},
    // strictly falling run
    '{32'sd3,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd2,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd0,  1'b1, 1'b0, 32'sd0,  7'd0},
    // mixed run with tail replacements and a negative element
    '{32'sd3,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd4,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd5,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd9,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd2,  1'b0, 1'b0, 32'sd0,  7'd0},
    '{32'sd6,  1'b1, 1'b0, 32'sd0,  7'd0}
  };

  // dut ports, the driven ones known from time zero
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [VALUE_W-1:0] in_value_i  = '0;
  logic                      is_final_i  = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0] out_value_o;
  logic [LEN_W-1:0]          seq_length_o;
  logic                      end_of_run_o;
  logic                      overflowed_o;

  // predictor state: stored values, best tail index per chain length,
  // predecessor index per stored value
  logic signed [VALUE_W-1:0] value_mem [MAX_ITEMS];
  logic [5:0]                tail_mem  [MAX_ITEMS+1];
  logic [5:0]                pred_mem  [MAX_ITEMS];
  logic [LEN_W-1:0]          chain_len    = '0;
  int unsigned               stored_cnt   = 0;
  logic                      dropped_flag = 1'b0;

  // expected subsequence elements, oldest first
  subseq_elem_t subseq_q [$];

  // run bookkeeping
  int unsigned err_cnt     = 0;
  int unsigned elem_cnt    = 0;
  int unsigned result_cnt  = 0;
  int unsigned seq_cnt     = 0;
  int unsigned ovf_seq_cnt = 0;
  int unsigned cycle_cnt   = 0;

  // idle controls, changed between sequences
  bit in_gap_en  = 1'b0;
  bit out_gap_en = 1'b0;
  int stall_left = 0;

  longest_increasing_subsequence #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_value_i  (in_value_i),
    .is_final_i  (is_final_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .seq_length_o(seq_length_o),
    .end_of_run_o(end_of_run_o),
    .overflowed_o(overflowed_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // update the predictor with one accepted element; on the final element
  // walk the predecessor chain backwards and queue the subsequence
  task automatic track_element(input logic signed [VALUE_W-1:0] v, input logic fin,
                               input bit queue_it);
    int unsigned               best_j;
    int unsigned               len;
    logic [5:0]                idx;
    logic [5:0]                pos;
    logic signed [VALUE_W-1:0] chain [MAX_ITEMS];
    if (stored_cnt < MAX_ITEMS) begin
      idx = stored_cnt[5:0];
      value_mem[idx] = v;
      // longest chain whose tail is strictly below the new value
      best_j = 0;
      for (int j = 1; j <= chain_len; j++) begin
        if (value_mem[tail_mem[j]] < v) begin
          best_j = j;
        end
      end
      pred_mem[idx] = tail_mem[best_j];
      // extend the best chain, or take over a longer chain with a larger tail
      if (best_j == chain_len || v < value_mem[tail_mem[best_j+1]]) begin
        if (best_j + 1 > chain_len) begin
          chain_len = LEN_W'(best_j + 1);
        end
        tail_mem[best_j+1] = idx;
      end
      stored_cnt++;
    end else begin
      // no room left: element is dropped
      dropped_flag = 1'b1;
    end
    if (fin) begin
      len = chain_len;
      pos = tail_mem[len];
      for (int k = len; k > 0; k--) begin
        chain[k-1] = value_mem[pos];
        pos = pred_mem[pos];
      end
      if (queue_it) begin
        for (int k = 0; k < len; k++) begin
          subseq_q.push_back('{chain[k], len[LEN_W-1:0], (k + 1 == len), dropped_flag});
        end
      end
      if (dropped_flag) begin
        ovf_seq_cnt++;
      end
      seq_cnt++;
      chain_len    = '0;
      stored_cnt   = 0;
      dropped_flag = 1'b0;
    end
  endtask

  // drive one element from a falling edge, hold it until the transfer,
  // and return at the next falling edge
  task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic fin,
                              input bit typed, input logic signed [VALUE_W-1:0] tv,
                              input logic [LEN_W-1:0] tl);
    if (in_gap_en && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_value_i <= v;
    is_final_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    // transfer taken at this edge
    track_element(v, fin, !typed);
    if (typed) begin
      subseq_q.push_back('{tv, tl, 1'b1, 1'b0});
    end
    elem_cnt++;
    @(negedge clk_i);
  endtask

  // value for position k of a random sequence of the given flavor
  function automatic logic signed [VALUE_W-1:0] pick_value(input value_mix_e mix,
                                                           input int k);
    case (mix)
      MIX_RANDOM: begin
        return $urandom;
      end
      MIX_NARROW: begin
        // tight range, so equal values show up often
        return int'($urandom_range(0, 16)) - 8;
      end
      MIX_RISING: begin
        // noisy ramp, gives long chains with frequent tail replacement
        return k * 1000 + int'($urandom_range(0, 2500)) - 1000;
      end
      MIX_FALLING: begin
        return 1_000_000 - k * 100 + int'($urandom_range(0, 150));
      end
      default: begin
        case ($urandom_range(0, 6))
          0:       return VMIN;
          1:       return VMIN + 1;
          2:       return -32'sd1;
          3:       return 32'sd0;
          4:       return 32'sd1;
          5:       return VMAX - 1;
          default: return VMAX;
        endcase
      end
    endcase
  endfunction

  // output stall in random bursts while output gaps are enabled
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (out_gap_en && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic cmp_field(input string fname, input longint expv, input longint actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", fname, expv, actv);
      err_cnt++;
    end
  endtask

  // compare every output transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    subseq_elem_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (subseq_q.size() == 0) begin
        $error("unexpected result: out_value %0d with nothing pending", out_value_o);
        err_cnt++;
      end else begin
        want = subseq_q.pop_front();
        cmp_field("out_value", longint'(want.value), longint'(out_value_o));
        cmp_field("seq_length", longint'(want.len), longint'(seq_length_o));
        cmp_field("end_of_run", longint'(want.last), longint'(end_of_run_o));
        cmp_field("overflowed", longint'(want.ovf), longint'(overflowed_o));
        result_cnt++;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_cnt, subseq_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int         n;
    int         seq_no;
    value_mix_e mix;
    // predictor stores start out cleared
    for (int i = 0; i < MAX_ITEMS; i++) begin
      value_mem[i] = '0;
      pred_mem[i]  = '0;
    end
    for (int i = 0; i <= MAX_ITEMS; i++) begin
      tail_mem[i] = '0;
    end

    // reset held from time zero, released on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows, a few with idling on both sides
    in_gap_en  = 1'b1;
    out_gap_en = 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_element(dir_rows[r].value, dir_rows[r].last_item, dir_rows[r].typed,
                   dir_rows[r].exp_value, dir_rows[r].exp_len);
    end

    // random sequences; the first two sit right at capacity: one element
    // over it (the dropped element is the final one), then exactly full
    seq_no = 0;
    while (elem_cnt < ITEM_TARGET) begin
      if (elem_cnt + QUIET_TAIL >= ITEM_TARGET) begin
        in_gap_en  = 1'b0;
        out_gap_en = 1'b0;
      end else begin
        in_gap_en  = ($urandom_range(0, 3) != 0);
        out_gap_en = ($urandom_range(0, 3) != 0);
      end
      if (seq_no == 0) begin
        n   = MAX_ITEMS + 1;
        mix = MIX_RISING;
      end else if (seq_no == 1) begin
        n   = MAX_ITEMS;
        mix = MIX_RANDOM;
      end else begin
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 6)
                                          : $urandom_range(1, 16);
        mix = ($urandom_range(0, 2) == 0) ? MIX_RISING : value_mix_e'($urandom_range(0, 4));
      end
      for (int k = 0; k < n; k++) begin
        send_element(pick_value(mix, k), (k == n - 1), 1'b0, '0, '0);
      end
      seq_no++;
    end
    in_valid_i <= 1'b0;

    // drain, then linger to catch stray transfers
    while (subseq_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("run covered %0d sequences, %0d elements in, %0d subsequence elements checked",
             seq_cnt, elem_cnt, result_cnt);
    $display("%0d sequences ran past capacity and dropped elements", ovf_seq_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
